// File: rtl/core/fbd_pkg.sv
// ----------------------------------------------------------------------------
// fbd_pkg
// shared widths, constants and controller/datapath structs for the
// fractional baud divisor calculator
// ----------------------------------------------------------------------------
package fbd_pkg;

    localparam int BAUD_W   = 23;   // requested rate
    localparam int RATE_W   = 24;   // rate after doubling
    localparam int CLK_W    = 26;   // clock register
    localparam int DIVO_W   = 12;   // divisor port
    localparam int EXP_W    = 4;    // signed scale exponent
    localparam int NUM_W    = 34;   // dividend of the rounded quotient
    localparam int DEN_W    = 34;   // divisor of the rounded quotient
    localparam int CNT_W    = $clog2(NUM_W);
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [CLK_W-1:0] CLOCK_HZ_RESET = 26'd32000000;
    localparam logic             REG_CLOCK_HZ   = 1'b0;   // word index of clock_hz

    localparam logic signed [EXP_W-1:0] EXP_MIN  = -4'sd7;
    localparam logic signed [EXP_W-1:0] EXP_MAX  = 4'sd7;
    localparam logic signed [EXP_W-1:0] EXP_FILL = -4'sd3;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture the input word, seed the search
        logic step;       // one exponent search step
        logic div_init;   // set up dividend and divisor
        logic div_step;   // one restoring division step
        logic finish;     // register the result word
        logic fail;       // result word is the invalid one
    } fbd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic rate_zero;
        logic search_done;
        logic bad_rate;   // clock below eight times the rate, negative exponent
    } fbd_sts_t;

endpackage

// File: rtl/core/fbd_ctrl.sv
// ----------------------------------------------------------------------------
// fbd_ctrl
// sequencer: exponent search, division steps and result strobe
// ----------------------------------------------------------------------------
module fbd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  fbd_pkg::fbd_sts_t sts,
    output fbd_pkg::fbd_cmd_t cmd,
    output logic              busy,
    output logic              done
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    localparam logic [fbd_pkg::CNT_W-1:0] LAST_CNT = fbd_pkg::CNT_W'(fbd_pkg::NUM_W - 1);

    state_t                      state_reg, state_next;
    logic [fbd_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && !busy_reg)
                begin
                    cmd.load   = 1'b1;
                    busy_next  = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (sts.rate_zero || (sts.search_done && sts.bad_rate))
                begin
                    cmd.finish = 1'b1;
                    cmd.fail   = 1'b1;
                    busy_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (sts.search_done)
                begin
                    cmd.div_init = 1'b1;
                    cnt_next     = LAST_CNT;
                    state_next   = ST_DIVIDE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - fbd_pkg::CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                busy_next  = 1'b0;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// File: rtl/core/fbd_datapath.sv
// ----------------------------------------------------------------------------
// fbd_datapath
// exponent search by running product, restoring divider, result registers
// ----------------------------------------------------------------------------
module fbd_datapath
#(
    parameter int DIVISOR_BITS = 12
)
(
    input  logic                                  clk,
    input  logic [fbd_pkg::CLK_W-1:0]             clock_hz,
    input  logic [fbd_pkg::BAUD_W-1:0]            baud_rate,
    input  logic                                  double_speed,
    input  fbd_pkg::fbd_cmd_t                     cmd,
    output fbd_pkg::fbd_sts_t                     sts,
    output logic [fbd_pkg::DIVO_W-1:0]            divisor,
    output logic signed [fbd_pkg::EXP_W-1:0]      scale_exponent,
    output logic                                  invalid
);

    // product of limit and rate; once a step is taken it stays at most 2*clock + rate
    localparam int PROD_W = (DIVISOR_BITS + 20 > 28) ? DIVISOR_BITS + 20 : 28;
    localparam logic [fbd_pkg::NUM_W-1:0] SEL_MASK =
        (fbd_pkg::NUM_W'(1) << DIVISOR_BITS) - fbd_pkg::NUM_W'(1);

    logic [fbd_pkg::RATE_W-1:0]          rate_reg;
    logic [PROD_W-1:0]                   prod_reg;
    logic signed [fbd_pkg::EXP_W-1:0]    exp_reg;
    logic [fbd_pkg::NUM_W-1:0]           quo_reg;
    logic [fbd_pkg::DEN_W-1:0]           rem_reg;
    logic [fbd_pkg::DEN_W-1:0]           den_reg;
    logic [fbd_pkg::DIVO_W-1:0]          divisor_reg;
    logic signed [fbd_pkg::EXP_W-1:0]    exp_out_reg;
    logic                                invalid_reg;

    logic [fbd_pkg::RATE_W-1:0]          rate_in;
    logic [PROD_W-1:0]                   prod_seed;
    logic [PROD_W-1:0]                   prod_step;
    logic [fbd_pkg::CLK_W:0]             rate8;
    logic [fbd_pkg::CLK_W:0]             clk_minus;
    logic [fbd_pkg::EXP_W-1:0]           exp_bits;
    logic [2:0]                          sh_neg;
    logic [3:0]                          sh_pos;
    logic [fbd_pkg::NUM_W-1:0]           rate_sh;
    logic [fbd_pkg::NUM_W-1:0]           num_init;
    logic [fbd_pkg::DEN_W-1:0]           den_init;
    logic [fbd_pkg::DEN_W:0]             trial;
    logic [fbd_pkg::DEN_W:0]             trial_diff;
    logic                                qbit;
    logic [fbd_pkg::NUM_W-1:0]           sel;

    assign rate_in   = double_speed ? {1'b0, baud_rate} : {baud_rate, 1'b0};
    assign prod_seed = (PROD_W'(rate_in) << (DIVISOR_BITS - 4)) - PROD_W'(rate_in);
    // limit doubles each step, with a low one while the exponent is below -3
    assign prod_step = {prod_reg[PROD_W-2:0], 1'b0}
                     + ((exp_reg < fbd_pkg::EXP_FILL) ? PROD_W'(rate_reg) : '0);

    assign rate8     = {rate_reg, 3'b000};
    assign clk_minus = {1'b0, clock_hz} - rate8;

    assign sts.rate_zero   = (rate_reg == '0);
    assign sts.search_done = (PROD_W'(clock_hz) < prod_reg) || (exp_reg == fbd_pkg::EXP_MAX);
    assign sts.bad_rate    = (exp_reg < 0) && ({1'b0, clock_hz} < rate8);

    assign exp_bits = exp_reg;
    assign sh_neg   = 3'(fbd_pkg::EXP_FILL - exp_reg);
    assign sh_pos   = exp_bits + 4'd3;
    assign rate_sh  = fbd_pkg::NUM_W'(rate_reg) << sh_pos;

    always_comb
    begin
        if (exp_reg <= fbd_pkg::EXP_FILL)
        begin
            num_init = (fbd_pkg::NUM_W'(clk_minus) << sh_neg)
                     + fbd_pkg::NUM_W'(rate_reg >> 1);
            den_init = fbd_pkg::DEN_W'(rate_reg);
        end
        else if (exp_reg < 0)
        begin
            num_init = fbd_pkg::NUM_W'(clk_minus) + (rate_sh >> 1);
            den_init = fbd_pkg::DEN_W'(rate_sh);
        end
        else
        begin
            num_init = fbd_pkg::NUM_W'(clock_hz) + (rate_sh >> 1);
            den_init = fbd_pkg::DEN_W'(rate_sh);
        end
    end

    // restoring division, one quotient bit per step
    assign trial      = {rem_reg, quo_reg[fbd_pkg::NUM_W-1]};
    assign trial_diff = trial - {1'b0, den_reg};
    assign qbit       = (trial >= {1'b0, den_reg});

    // non-negative exponent subtracts one, saturating at zero
    assign sel = ((exp_reg >= 0) && (quo_reg != '0)) ? quo_reg - fbd_pkg::NUM_W'(1)
               : (exp_reg >= 0) ? '0 : quo_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rate_reg <= rate_in;
            prod_reg <= prod_seed;
            exp_reg  <= fbd_pkg::EXP_MIN;
        end
        else if (cmd.step)
        begin
            prod_reg <= prod_step;
            exp_reg  <= exp_reg + 4'sd1;
        end

        if (cmd.div_init)
        begin
            quo_reg <= num_init;
            rem_reg <= '0;
            den_reg <= den_init;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[fbd_pkg::NUM_W-2:0], qbit};
            rem_reg <= qbit ? trial_diff[fbd_pkg::DEN_W-1:0] : trial[fbd_pkg::DEN_W-1:0];
        end

        if (cmd.finish)
        begin
            if (cmd.fail)
            begin
                divisor_reg <= '0;
                exp_out_reg <= '0;
                invalid_reg <= 1'b1;
            end
            else
            begin
                divisor_reg <= fbd_pkg::DIVO_W'(sel & SEL_MASK);
                exp_out_reg <= exp_reg;
                invalid_reg <= 1'b0;
            end
        end
    end

    assign divisor        = divisor_reg;
    assign scale_exponent = exp_out_reg;
    assign invalid        = invalid_reg;

endmodule

// File: rtl/core/fractional_baud_divisor_calc.sv
// ----------------------------------------------------------------------------
// fractional_baud_divisor_calc
// fractional baud rate divisor and scale exponent from clock and baud rate
// ----------------------------------------------------------------------------
// channel   direction  handshake                     payload
// config    in         psel & penable & pwrite       paddr, pwdata (clock_hz)
// request   in         start & !busy                 baud_rate, double_speed
// result    out        done, one cycle               divisor, scale_exponent, invalid
//
// a word is loaded on accept, then runs the exponent search (one limit step per
// cycle), the bit-serial divider and a finish step; a rejected rate ends in the
// search with an invalid result
// one word at a time: busy stays high from accept until done
// reset sets clock_hz to 32000000 and idles the sequencer
// results cannot be stalled; done marks each word for exactly one cycle
// ----------------------------------------------------------------------------
module fractional_baud_divisor_calc
#(
    parameter int DIVISOR_BITS = 12
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fbd_pkg::ADDR_W-1:0]          paddr,
    input  logic [fbd_pkg::DATA_W-1:0]          pwdata,
    output logic [fbd_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    input  logic                                start,
    output logic                                busy,
    input  logic [fbd_pkg::BAUD_W-1:0]          baud_rate,
    input  logic                                double_speed,
    output logic                                done,
    output logic [fbd_pkg::DIVO_W-1:0]          divisor,
    output logic signed [fbd_pkg::EXP_W-1:0]    scale_exponent,
    output logic                                invalid
);

    logic [fbd_pkg::CLK_W-1:0] clock_hz_reg, clock_hz_next;
    logic                      wr_en;
    logic                      sel_clock;
    fbd_pkg::fbd_cmd_t         cmd;
    fbd_pkg::fbd_sts_t         sts;

    // word index from the byte address
    assign sel_clock = (paddr[2] == fbd_pkg::REG_CLOCK_HZ);
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = sel_clock ? fbd_pkg::DATA_W'(clock_hz_reg) : '0;

    assign clock_hz_next = (wr_en && sel_clock) ? pwdata[fbd_pkg::CLK_W-1:0] : clock_hz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg <= fbd_pkg::CLOCK_HZ_RESET;
        end
        else
        begin
            clock_hz_reg <= clock_hz_next;
        end
    end

    fbd_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    fbd_datapath
    #(
        .DIVISOR_BITS (DIVISOR_BITS)
    )
    u_datapath
    (
        .clk            (clk),
        .clock_hz       (clock_hz_reg),
        .baud_rate      (baud_rate),
        .double_speed   (double_speed),
        .cmd            (cmd),
        .sts            (sts),
        .divisor        (divisor),
        .scale_exponent (scale_exponent),
        .invalid        (invalid)
    );

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a word in flight");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && invalid) |-> (divisor == '0 && scale_exponent == '0))
        else $error("invalid result carries nonzero fields");
`endif

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the fractional baud divisor calculator: every
// accepted request word is run through a bit-accurate divisor predictor,
// each result word is compared field by field in order, and the clock
// register is reprogrammed over the apb port between phases of random
// traffic with varying sender idling
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DIVISOR_BITS    = 12;
    localparam int NUM_PHASES      = 9;
    localparam int WORDS_PER_PHASE = 48;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 60;

    localparam logic [fbd_pkg::ADDR_W-1:0] ADDR_CLOCK_HZ =
        fbd_pkg::ADDR_W'(fbd_pkg::REG_CLOCK_HZ) << 2;
    localparam logic [63:0]       DIV_MASK      = (64'd1 << DIVISOR_BITS) - 64'd1;

    localparam int unsigned COMMON_RATES [8] =
        '{300, 1200, 9600, 19200, 57600, 115200, 921600, 8000000};

    typedef struct packed {
        logic [fbd_pkg::DIVO_W-1:0]        divisor;
        logic signed [fbd_pkg::EXP_W-1:0]  scale_exponent;
        logic                              invalid;
    } baud_result_t;

    class divisor_checker;
        logic [fbd_pkg::CLK_W-1:0] clock_hz;
        baud_result_t              pending_divisors [$];
        int                        errors;

        function new();
            clock_hz = fbd_pkg::CLOCK_HZ_RESET;
            errors   = 0;
        endfunction

        function void set_clock(logic [fbd_pkg::CLK_W-1:0] hz);
            clock_hz = hz;
        endfunction

        function int pending();
            return pending_divisors.size();
        endfunction

        function baud_result_t predict_divisor(logic [fbd_pkg::BAUD_W-1:0] rate, logic dbl);
            baud_result_t r;
            logic [63:0]  b, c, ratio, limit, bs, c8, q, sel;
            int           e;
            r         = '0;
            r.invalid = 1'b1;
            b = 64'(rate);
            if (!dbl)
                b = b << 1;
            c = 64'(clock_hz);
            if (b == 64'd0)
                return r;
            ratio = c / b;
            limit = DIV_MASK >> 4;
            // exponent search, limit gets a one filled in below -3
            for (e = -7; e < 7; e++)
            begin
                if (ratio < limit)
                    break;
                limit = limit << 1;
                if (e < -3)
                    limit[0] = 1'b1;
            end
            if (e < 0)
            begin
                if (c < (b << 3))
                    return r;
                c8 = c - (b << 3);
                if (e <= -3)
                    sel = ((c8 << (-e - 3)) + b / 64'd2) / b;
                else
                begin
                    bs  = b << (e + 3);
                    sel = (c8 + bs / 64'd2) / bs;
                end
            end
            else
            begin
                bs  = b << (e + 3);
                q   = (c + bs / 64'd2) / bs;
                sel = (q == 64'd0) ? 64'd0 : q - 64'd1;
            end
            r.invalid        = 1'b0;
            r.divisor        = fbd_pkg::DIVO_W'(sel & DIV_MASK);
            r.scale_exponent = fbd_pkg::EXP_W'(e);
            return r;
        endfunction

        function void note_request(logic [fbd_pkg::BAUD_W-1:0] rate, logic dbl);
            pending_divisors.push_back(predict_divisor(rate, dbl));
        endfunction

        function void check_result(baud_result_t got);
            baud_result_t want;
            if (pending_divisors.size() == 0)
            begin
                $display("%0t: unexpected result word: divisor %0d exponent %0d invalid %0b",
                         $time, got.divisor, got.scale_exponent, got.invalid);
                errors++;
                return;
            end
            want = pending_divisors.pop_front();
            if (got.divisor !== want.divisor)
            begin
                $display("%0t: divisor mismatch: expected %0d actual %0d",
                         $time, want.divisor, got.divisor);
                errors++;
            end
            if (got.scale_exponent !== want.scale_exponent)
            begin
                $display("%0t: scale_exponent mismatch: expected %0d actual %0d",
                         $time, want.scale_exponent, got.scale_exponent);
                errors++;
            end
            if (got.invalid !== want.invalid)
            begin
                $display("%0t: invalid mismatch: expected %0b actual %0b",
                         $time, want.invalid, got.invalid);
                errors++;
            end
        endfunction
    endclass

    logic                                 clk          = 1'b0;
    logic                                 rst_n        = 1'b0;
    logic                                 psel         = 1'b0;
    logic                                 penable      = 1'b0;
    logic                                 pwrite       = 1'b0;
    logic [fbd_pkg::ADDR_W-1:0]           paddr        = '0;
    logic [fbd_pkg::DATA_W-1:0]           pwdata       = '0;
    logic [fbd_pkg::DATA_W-1:0]           prdata;
    logic                                 pready;
    logic                                 start        = 1'b0;
    logic                                 busy;
    logic [fbd_pkg::BAUD_W-1:0]           baud_rate    = '0;
    logic                                 double_speed = 1'b0;
    logic                                 done;
    logic [fbd_pkg::DIVO_W-1:0]           divisor;
    logic signed [fbd_pkg::EXP_W-1:0]     scale_exponent;
    logic                                 invalid;

    divisor_checker divisor_sb;
    int             idle_pct    = 0;
    int             quiet_count = 0;

    always #1 clk = ~clk;

    fractional_baud_divisor_calc #(
        .DIVISOR_BITS (DIVISOR_BITS)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .baud_rate      (baud_rate),
        .double_speed   (double_speed),
        .done           (done),
        .divisor        (divisor),
        .scale_exponent (scale_exponent),
        .invalid        (invalid)
    );

    // request and result monitor, sees pre-edge values
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            divisor_sb.note_request(baud_rate, double_speed);
        if (rst_n && done)
            divisor_sb.check_result('{divisor, scale_exponent, invalid});
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable && pwrite && pready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic send_request(input logic [fbd_pkg::BAUD_W-1:0] rate, input logic dbl);
        logic offer;
        baud_rate    <= rate;
        double_speed <= dbl;
        // sender holds off in each cycle with the phase's idle odds
        forever
        begin
            offer = ($urandom_range(99) >= idle_pct);
            start <= offer;
            @(posedge clk);
            if (offer && !busy)
                break;
        end
    endtask

    task automatic write_clock(input logic [fbd_pkg::CLK_W-1:0] hz);
        // only reprogram once the last word has come back
        do
            @(posedge clk);
        while (divisor_sb.pending() != 0 || busy);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CLOCK_HZ;
        pwdata  <= fbd_pkg::DATA_W'(hz);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        divisor_sb.set_clock(hz);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [fbd_pkg::BAUD_W-1:0] random_rate();
        int unsigned pick;
        int unsigned bits;
        pick = $urandom_range(39);
        if (pick == 0)
            return '0;
        if (pick < 8)
            return fbd_pkg::BAUD_W'($urandom);
        if (pick < 14)
            return fbd_pkg::BAUD_W'(COMMON_RATES[$urandom_range(7)]);
        // log-uniform spread reaches every exponent
        bits = $urandom_range(1, fbd_pkg::BAUD_W);
        return fbd_pkg::BAUD_W'(($urandom & ((32'd1 << bits) - 32'd1)) | (32'd1 << (bits - 1)));
    endfunction

    initial
    begin
        logic [fbd_pkg::CLK_W-1:0] hz;
        divisor_sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words at the reset clock
        send_request(23'd0, 1'b0);
        send_request(23'd0, 1'b1);
        send_request(23'd1, 1'b0);
        send_request(23'd1, 1'b1);
        send_request(23'd8000000, 1'b0);
        send_request(23'd8000000, 1'b1);
        send_request(23'h7FFFFF, 1'b1);
        send_request(23'h7FFFFF, 1'b0);
        send_request(23'd4000000, 1'b0);   // clock below eight times the rate
        send_request(23'd2000000, 1'b0);   // clock exactly eight times the rate
        send_request(23'd1200, 1'b0);      // exponent between -3 and 0
        send_request(23'd2400, 1'b1);
        send_request(23'd9600, 1'b0);
        send_request(23'd115200, 1'b0);
        send_request(23'd115200, 1'b1);
        send_request(23'd300, 1'b0);
        send_request(23'd50, 1'b1);        // search stops at exponent 5
        send_request(23'd1999999, 1'b0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
            begin
                case (p)
                    1:       hz = 26'd64000000;
                    2:       hz = 26'd1;
                    3:       hz = 26'd0;
                    4:       hz = 26'h3FFFFFF;
                    5:       hz = 26'd7372800;
                    7:       hz = 26'd16000000;
                    default: hz = fbd_pkg::CLK_W'($urandom_range(1, 64000000));
                endcase
                write_clock(hz);
            end
            idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 70 : 38;
            repeat (WORDS_PER_PHASE)
                send_request(random_rate(), 1'($urandom_range(1)));
            start <= 1'b0;
        end

        do
            @(posedge clk);
        while (divisor_sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (divisor_sb.errors == 0 && divisor_sb.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/core/fbd_pkg.sv
rtl/core/fbd_ctrl.sv
rtl/core/fbd_datapath.sv
rtl/core/fractional_baud_divisor_calc.sv
sim/tb_top.sv
